[src/crf_pkg.sv]
`timescale 1ns / 1ps

package crf_pkg;

    // Channel, product and divisor widths
    localparam int CHAN_W = 8;
    localparam int PROD_W = 16;
    localparam int DIV_W  = 10;

    // Quotient bits resolved in each divider stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;

    // Product stage, divider stages, output register
    localparam int LATENCY = DIV_STAGES + 2;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Partial state of one restoring division as it moves down the pipe
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DIV_W-1:0]  dvs;
        logic [CHAN_W-1:0] quo;
        logic              sat;
    } crf_div_t;

endpackage

[src/color_ratio_fire_filter.sv]
`timescale 1ns / 1ps

// Colour ratio ("fire") filter. Each pixel request (blue_in, green_in, red_in)
// is taken at any rising edge with start high; busy is always low, so a new
// pixel may follow in every cycle and the block never pushes back. Each
// output channel is floor(own * 255 / (sum of the other two + 1)), saturated
// at 255. The result appears on blue_out, green_out and red_out for exactly
// one cycle, marked by done: it is driven from the output register, which
// follows the product register and the divider stage registers. The
// receiver must take it then, since the block cannot hold it. The pipeline
// depth is set by the restoring divider in each channel: one stage forms the
// product and divisor, four stages resolve two quotient bits each, and one
// register drives the outputs. Throughput is one pixel per clock.
module color_ratio_fire_filter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [crf_pkg::CHAN_W-1:0] blue_in,
    input  logic [crf_pkg::CHAN_W-1:0] green_in,
    input  logic [crf_pkg::CHAN_W-1:0] red_in,
    output logic                      done,
    output logic [crf_pkg::CHAN_W-1:0] blue_out,
    output logic [crf_pkg::CHAN_W-1:0] green_out,
    output logic [crf_pkg::CHAN_W-1:0] red_out
);

    localparam int LAT = crf_pkg::LATENCY;

    // One valid bit per pipeline register, travelling with the payload
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    // Never stall: every stage advances on every clock
    assign busy = 1'b0;

    // Advance the valid bits; a request enters at the bottom
    assign valid_next = {valid_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Blue against green and red
    crf_lane u_blue
    (
        .clk     (clk),
        .own     (blue_in),
        .other_a (green_in),
        .other_b (red_in),
        .result  (blue_out)
    );

    // Green against blue and red
    crf_lane u_green
    (
        .clk     (clk),
        .own     (green_in),
        .other_a (blue_in),
        .other_b (red_in),
        .result  (green_out)
    );

    // Red against green and blue
    crf_lane u_red
    (
        .clk     (clk),
        .own     (red_in),
        .other_a (green_in),
        .other_b (blue_in),
        .result  (red_out)
    );

    // Flag the result for its single cycle on the outputs
    assign done = valid_reg[LAT-1];

endmodule

[src/crf_lane.sv]
`timescale 1ns / 1ps

// One channel: own * 255 / (other_a + other_b + 1), floored, saturated at 255.
// Restoring division, two quotient bits per stage. Payload only; the caller
// tracks validity.
module crf_lane
(
    input  logic                      clk,
    input  logic [crf_pkg::CHAN_W-1:0] own,
    input  logic [crf_pkg::CHAN_W-1:0] other_a,
    input  logic [crf_pkg::CHAN_W-1:0] other_b,
    output logic [crf_pkg::CHAN_W-1:0] result
);

    localparam int CW  = crf_pkg::CHAN_W;
    localparam int PW  = crf_pkg::PROD_W;
    localparam int DW  = crf_pkg::DIV_W;
    localparam int NS  = crf_pkg::DIV_STAGES;
    localparam int BPS = crf_pkg::BITS_PER_STAGE;
    localparam int SW  = DW + CW;

    logic [PW-1:0]     prod_reg;
    logic [DW-1:0]     dvs_reg;
    logic [PW-1:0]     prod_next;
    logic [DW-1:0]     dvs_next;
    crf_pkg::crf_div_t st_in [NS];
    crf_pkg::crf_div_t st_reg [NS];
    crf_pkg::crf_div_t st_next [NS];
    logic [CW-1:0]     result_reg;
    logic [CW-1:0]     result_next;

    // own * 255 as (own << 8) - own
    assign prod_next = {own, {(PW - CW){1'b0}}} - {{(PW - CW){1'b0}}, own};
    assign dvs_next  = {{(DW - CW){1'b0}}, other_a} + {{(DW - CW){1'b0}}, other_b}
                       + DW'(1);

    // Saturate when the quotient would need a ninth bit
    always_comb
    begin
        st_in[0].rem = prod_reg;
        st_in[0].dvs = dvs_reg;
        st_in[0].quo = '0;
        st_in[0].sat = ({{(SW - PW){1'b0}}, prod_reg} >= {dvs_reg, {CW{1'b0}}});
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign st_in[s] = st_reg[s-1];
        end

        always_comb
        begin
            logic [SW-1:0] trial;
            st_next[s] = st_in[s];
            for (int j = 0; j < BPS; j++)
            begin
                trial = {{CW{1'b0}}, st_in[s].dvs} << (CW - 1 - s * BPS - j);
                if ({{(SW - PW){1'b0}}, st_next[s].rem} >= trial)
                begin
                    st_next[s].rem = st_next[s].rem - trial[PW-1:0];
                    st_next[s].quo = st_next[s].quo
                                     | (CW'(1) << (CW - 1 - s * BPS - j));
                end
            end
        end
    end

    assign result_next = st_reg[NS-1].sat ? crf_pkg::CHAN_MAX : st_reg[NS-1].quo;

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        dvs_reg    <= dvs_next;
        st_reg     <= st_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[tb/sv/tb_color_ratio_fire_filter.sv]
`timescale 1ns / 1ps

module tb_color_ratio_fire_filter;

    localparam int CW = crf_pkg::CHAN_W;

    // One pixel, used both for queued requests and for predicted results
    typedef struct {
        logic [CW-1:0] blue;
        logic [CW-1:0] green;
        logic [CW-1:0] red;
    } pixel_t;

    // Watchdog limit, far above what a correct run needs
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PIXELS = 1750;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [CW-1:0] blue_in = '0;
    logic [CW-1:0] green_in = '0;
    logic [CW-1:0] red_in = '0;
    logic          busy;
    logic          done;
    logic [CW-1:0] blue_out;
    logic [CW-1:0] green_out;
    logic [CW-1:0] red_out;

    // Requests waiting to be driven, and recoloured pixels still owed by the block
    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];

    int          error_count = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          saturated_seen = 0;
    int unsigned cycle_count = 0;

    // Burst shaping for the sender: burst_left requests, then gap_left idle cycles
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    color_ratio_fire_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .done      (done),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predict one output channel: own * 255 over (other two + 1), floored,
    // then clamped to the channel maximum. The quotient is never negative.
    function automatic logic [CW-1:0] fire_ratio(input logic [CW-1:0] own,
                                                 input logic [CW-1:0] other_a,
                                                 input logic [CW-1:0] other_b);
        int unsigned divisor;
        int unsigned quotient;
        divisor  = int'(other_a) + int'(other_b) + 1;
        quotient = (int'(own) * 255) / divisor;
        if (quotient > int'(crf_pkg::CHAN_MAX))
        begin
            quotient = int'(crf_pkg::CHAN_MAX);
        end
        return quotient[CW-1:0];
    endfunction

    task automatic queue_pixel(input logic [CW-1:0] b,
                               input logic [CW-1:0] g,
                               input logic [CW-1:0] r);
        pixel_t px;
        px.blue  = b;
        px.green = g;
        px.red   = r;
        pending_pixels.push_back(px);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Driver: a request is taken at an edge where start is high and busy is low.
    // On a taken request, record its prediction; then either hold the current
    // request, idle through a gap, or advance to the next queued pixel. Each
    // driven signal receives a single nonblocking assignment per edge.
    always @(posedge clk)
    begin : pixel_driver
        pixel_t next_px;
        pixel_t want;
        logic   taken;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                want.blue  = fire_ratio(blue_in, green_in, red_in);
                want.green = fire_ratio(green_in, blue_in, red_in);
                want.red   = fire_ratio(red_in, green_in, blue_in);
                expected_pixels.push_back(want);
                requests_sent++;
            end
            if (!start || taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_px = pending_pixels.pop_front();
                    blue_in  <= next_px.blue;
                    green_in <= next_px.green;
                    red_in   <= next_px.red;
                    start    <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // Mostly short bursts; now and then a long unbroken stretch
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(100, 300);
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 40);
                        end
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: done marks a result for exactly one cycle, so take it at this
    // edge and compare every channel with the oldest prediction.
    always @(posedge clk)
    begin : pixel_monitor
        pixel_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("result with no request pending: b=%0d g=%0d r=%0d",
                                          blue_out, green_out, red_out));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (blue_out !== want.blue)
                begin
                    report_mismatch($sformatf("blue_out got %0d, want %0d",
                                              blue_out, want.blue));
                end
                if (green_out !== want.green)
                begin
                    report_mismatch($sformatf("green_out got %0d, want %0d",
                                              green_out, want.green));
                end
                if (red_out !== want.red)
                begin
                    report_mismatch($sformatf("red_out got %0d, want %0d",
                                              red_out, want.red));
                end
                saturated_seen += (want.blue == crf_pkg::CHAN_MAX)
                                  + (want.green == crf_pkg::CHAN_MAX)
                                  + (want.red == crf_pkg::CHAN_MAX);
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CW-1:0] b;
        logic [CW-1:0] g;
        logic [CW-1:0] r;
        logic [CW-1:0] base;

        // Directed requests: black pixel, white pixel, lone channels (the
        // divisor drops to one and any nonzero channel saturates), and
        // near-boundary ratios.
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd1, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd1, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd1);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd255);
        queue_pixel(8'd1, 8'd1, 8'd1);
        queue_pixel(8'd1, 8'd0, 8'd1);
        queue_pixel(8'd2, 8'd1, 8'd0);
        queue_pixel(8'd255, 8'd127, 8'd127);
        queue_pixel(8'd255, 8'd128, 8'd127);
        queue_pixel(8'd128, 8'd64, 8'd63);
        queue_pixel(8'hAA, 8'h55, 8'hAA);
        queue_pixel(8'h55, 8'hAA, 8'h55);
        queue_pixel(8'd100, 8'd50, 8'd49);
        queue_pixel(8'd254, 8'd1, 8'd0);
        queue_pixel(8'd3, 8'd255, 8'd254);

        // Random requests across several pixel shapes, so that saturation,
        // exact ratios and tiny quotients all turn up often.
        repeat (RANDOM_PIXELS)
        begin
            b = CW'($urandom);
            g = CW'($urandom);
            r = CW'($urandom);
            case ($urandom_range(0, 9))
                4, 5:
                begin
                    // Two dim channels: the third one nearly always saturates
                    g = CW'($urandom_range(0, 3));
                    r = CW'($urandom_range(0, 3));
                end
                6:
                begin
                    b = CW'($urandom_range(200, 255));
                    g = CW'($urandom_range(0, 30));
                    r = CW'($urandom_range(0, 30));
                end
                7:
                begin
                    g = b;
                    r = b;
                end
                8:
                begin
                    b = CW'($urandom_range(0, 7));
                    g = CW'($urandom_range(0, 7));
                    r = CW'($urandom_range(0, 7));
                end
                9:
                begin
                    // Channels close together; exercise boundaries of the floor
                    base = CW'($urandom_range(2, 253));
                    g = CW'(base + $urandom_range(0, 2) - 1);
                    r = CW'(base + $urandom_range(0, 2) - 1);
                    b = CW'(base * 2 + $urandom_range(0, 2) - 1);
                end
                default:
                begin
                end
            endcase
            // Rotate which channel plays the leading role
            case ($urandom_range(0, 2))
                0: queue_pixel(b, g, r);
                1: queue_pixel(g, b, r);
                default: queue_pixel(g, r, b);
            endcase
        end

        // Hold reset, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait until every request is sent and every result has come
        while (pending_pixels.size() != 0 || start || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        // Watch a little longer for stray results
        repeat (crf_pkg::LATENCY + 4) @(posedge clk);

        $display("Run covered %0d pixel requests and %0d results, %0d saturated channels,",
                 requests_sent, results_seen, saturated_seen);
        $display("with bursty requests including black, white and lone-channel pixels.");
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
